>>> rtl/sti_pkg.sv
// ---------------------------------------------------------------------------
// sti_pkg
// Shared types and constants for the segment/triangle intersection core.
// ---------------------------------------------------------------------------
package sti_pkg;
  localparam int SLICE_BITS = 16;
  localparam int VEC_BITS   = 3 * SLICE_BITS;

  typedef struct packed {
    logic [VEC_BITS-1:0] seg_start;
    logic [VEC_BITS-1:0] seg_end;
    logic [VEC_BITS-1:0] vertex_a;
    logic [VEC_BITS-1:0] vertex_b;
    logic [VEC_BITS-1:0] vertex_c;
  } sti_in_t;

  typedef struct packed {
    logic               hit;
    logic               crosses_plane;
    logic signed [15:0] contact_x;
    logic signed [15:0] contact_y;
    logic signed [15:0] contact_z;
  } sti_out_t;
endpackage

>>> rtl/sti_if.sv
// ---------------------------------------------------------------------------
// sti_if
// Valid/ready channel carrying one payload transaction.
// ---------------------------------------------------------------------------
interface sti_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/sti_divider.sv
// ---------------------------------------------------------------------------
// sti_divider
// Pipelined restoring divider: one quotient bit per stage, remainder flag.
// ---------------------------------------------------------------------------
module sti_divider
  import sti_pkg::*;
#(
  parameter int NB = 8,
  parameter int QB = 4,
  parameter int TB = 4
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [NB-1:0] num_in,
  input  logic [NB-1:0] den_in,
  input  logic [TB-1:0] tag_in,
  output logic [QB-1:0] quo_out,
  output logic          rem_nz_out,
  output logic [TB-1:0] tag_out
);
  // stage k holds partial remainder, divisor and quotient so far
  logic [NB-1:0] rem_r [QB+1];
  logic [NB-1:0] den_r [QB+1];
  logic [QB-1:0] quo_r [QB+1];
  logic [TB-1:0] tag_r [QB+1];

  always_comb begin
    rem_r[0] = num_in;
    den_r[0] = den_in;
    quo_r[0] = '0;
    tag_r[0] = tag_in;
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SH = QB - 1 - k;
    logic [NB+QB-1:0] dsh;
    logic [NB+QB-1:0] rw;
    logic             ge;
    assign dsh = {{QB{1'b0}}, den_r[k]} << SH;
    assign rw  = {{QB{1'b0}}, rem_r[k]};
    assign ge  = rw >= dsh;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= ge ? NB'(rw - dsh) : rem_r[k];
        den_r[k+1] <= den_r[k];
        quo_r[k+1] <= quo_r[k] | (QB'(ge) << SH);
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  assign quo_out    = quo_r[QB];
  assign rem_nz_out = |rem_r[QB];
  assign tag_out    = tag_r[QB];
endmodule

>>> rtl/segment_triangle_intersect_core.sv
// Quotient width: 18 bits at default.
// Throughput: one transaction per cycle while out_ch is not stalled; set by the fully
// pipelined datapath (seven arithmetic stages, one divider bit per stage, one output stage).
// A stall freezes all stages together; a skid-free global enable holds data.
// Reset clears only the stage valid bits.
module segment_triangle_intersect_core
  import sti_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input logic clk,
  input logic rst_n,
  sti_if.sink   in_ch,
  sti_if.source out_ch
);
  localparam int EB  = (COORD_BITS > SLICE_BITS) ? SLICE_BITS :
                       ((COORD_BITS < 2) ? 2 : COORD_BITS);
  localparam int DB  = EB + 1;          // difference width
  localparam int NB1 = 2*DB + 1;        // normal component width
  localparam int PB  = NB1 + DB + 1;    // normal * diff product
  localparam int SB  = PB + 2;          // dot product
  localparam int QB  = DB + 1;          // quotient bits (t*|dv| < 2^DB)
  localparam int AB  = SB + DB;         // |num|*|dv|
  localparam int NPIPE = 8 + QB;

  typedef logic signed [DB-1:0]  d_t;
  typedef logic signed [NB1-1:0] n_t;
  typedef logic signed [SB-1:0]  s_t;

  // pipeline enable: output stage free or taken
  logic adv;
  logic [NPIPE-1:0] vld_r;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = vld_r[NPIPE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NPIPE-2:0], in_ch.valid};
  end

  function automatic d_t crd(input logic [VEC_BITS-1:0] w, input int i);
    logic [EB-1:0] v;
    v = w[i*SLICE_BITS +: EB];
    return d_t'(signed'(v));
  endfunction

  // stage 1: unpack and differences
  d_t s_r [3], dv_r [3], ab_r [3], ac_r [3], sa_r [3], as_r [3], bs_r [3], cs_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s_r[i]  <= crd(in_ch.data.seg_start, i);
        dv_r[i] <= crd(in_ch.data.seg_end, i) - crd(in_ch.data.seg_start, i);
        ab_r[i] <= crd(in_ch.data.vertex_b, i) - crd(in_ch.data.vertex_a, i);
        ac_r[i] <= crd(in_ch.data.vertex_c, i) - crd(in_ch.data.vertex_a, i);
        sa_r[i] <= crd(in_ch.data.seg_start, i) - crd(in_ch.data.vertex_a, i);
        as_r[i] <= crd(in_ch.data.vertex_a, i) - crd(in_ch.data.seg_start, i);
        bs_r[i] <= crd(in_ch.data.vertex_b, i) - crd(in_ch.data.seg_start, i);
        cs_r[i] <= crd(in_ch.data.vertex_c, i) - crd(in_ch.data.seg_start, i);
      end
    end
  end

  // stage 2: cross products (the plane normal, and an edge normal about start for each edge)
  function automatic n_t xc(input d_t p1, input d_t q2, input d_t p2, input d_t q1);
    return n_t'(p1 * q2) - n_t'(p2 * q1);
  endfunction
  n_t n_r [3], k0_r [3], k1_r [3], k2_r [3];
  d_t s2_r [3], dv2_r [3], sa2_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i]  <= xc(ab_r[(i+1)%3], ac_r[(i+2)%3], ab_r[(i+2)%3], ac_r[(i+1)%3]);
        k0_r[i] <= xc(as_r[(i+1)%3], bs_r[(i+2)%3], as_r[(i+2)%3], bs_r[(i+1)%3]);
        k1_r[i] <= xc(bs_r[(i+1)%3], cs_r[(i+2)%3], bs_r[(i+2)%3], cs_r[(i+1)%3]);
        k2_r[i] <= xc(cs_r[(i+1)%3], as_r[(i+2)%3], cs_r[(i+2)%3], as_r[(i+1)%3]);
      end
      s2_r <= s_r; dv2_r <= dv_r; sa2_r <= sa_r;
    end
  end

  // stage 3: dot product terms
  typedef logic signed [PB-1:0] p_t;
  p_t pds_r [3], pden_r [3], pk0_r [3], pk1_r [3], pk2_r [3];
  d_t s3_r [3], dv3_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pds_r[i]  <= p_t'(n_r[i] * sa2_r[i]);
        pden_r[i] <= p_t'(n_r[i] * dv2_r[i]);
        pk0_r[i]  <= p_t'(k0_r[i] * dv2_r[i]);
        pk1_r[i]  <= p_t'(k1_r[i] * dv2_r[i]);
        pk2_r[i]  <= p_t'(k2_r[i] * dv2_r[i]);
      end
      s3_r <= s2_r; dv3_r <= dv2_r;
    end
  end

  // stage 4: sums
  function automatic s_t sum3(input p_t a, input p_t b, input p_t c);
    return s_t'(a) + s_t'(b) + s_t'(c);
  endfunction
  s_t ds_r, den_r, g0_r, g1_r, g2_r;
  d_t s4_r [3], dv4_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      ds_r  <= sum3(pds_r[0], pds_r[1], pds_r[2]);
      den_r <= sum3(pden_r[0], pden_r[1], pden_r[2]);
      g0_r  <= sum3(pk0_r[0], pk0_r[1], pk0_r[2]);
      g1_r  <= sum3(pk1_r[0], pk1_r[1], pk1_r[2]);
      g2_r  <= sum3(pk2_r[0], pk2_r[1], pk2_r[2]);
      s4_r <= s3_r; dv4_r <= dv3_r;
    end
  end

  // stage 5: decisions; de = ds + den, num = -ds
  s_t de_w, num_w, anum_w, aden_w;
  logic cr_w, ht_w;
  function automatic logic okk(input s_t g, input logic dneg);
    return (g == '0) || (g[SB-1] == dneg);
  endfunction
  always_comb begin
    de_w   = ds_r + den_r;
    num_w  = -ds_r;
    anum_w = num_w[SB-1] ? -num_w : num_w;
    aden_w = den_r[SB-1] ? -den_r : den_r;
    cr_w = (den_r != '0)
        && ((ds_r == '0) || (de_w == '0) || (ds_r[SB-1] != de_w[SB-1]))
        && ((num_w == '0) || (num_w[SB-1] == den_r[SB-1]))
        && (anum_w <= aden_w);
    ht_w = okk(g0_r, den_r[SB-1]) && okk(g1_r, den_r[SB-1]) && okk(g2_r, den_r[SB-1]);
  end
  logic cr5_r, ht5_r, sgn5_r;
  s_t an5_r, ad5_r;
  d_t s5_r [3], dv5_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      cr5_r <= cr_w; ht5_r <= ht_w;
      sgn5_r <= num_w[SB-1] ^ den_r[SB-1];
      an5_r <= anum_w; ad5_r <= aden_w;
      s5_r <= s4_r; dv5_r <= dv4_r;
    end
  end

  // stage 6: |num| * |dv| split per coordinate (lower and upper halves)
  localparam int HB = (SB + 1) / 2;
  logic [HB+DB-1:0] plo_r [3], phi_r [3];
  logic neg6_r [3];
  logic cr6_r, ht6_r;
  s_t ad6_r;
  d_t s6_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [DB-1:0] adv_v;
        adv_v = dv5_r[i][DB-1] ? DB'(-dv5_r[i]) : DB'(dv5_r[i]);
        plo_r[i]  <= (HB+DB)'(an5_r[HB-1:0] * adv_v);
        phi_r[i]  <= (HB+DB)'(an5_r[SB-1:HB] * adv_v);
        neg6_r[i] <= sgn5_r ^ dv5_r[i][DB-1];
      end
      cr6_r <= cr5_r; ht6_r <= ht5_r; ad6_r <= ad5_r; s6_r <= s5_r;
    end
  end

  // stage 7: combine partial products
  logic [AB-1:0] pr7_r [3];
  logic neg7_r [3];
  logic cr7_r, ht7_r;
  s_t ad7_r;
  d_t s7_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pr7_r[i]  <= AB'(plo_r[i]) + (AB'(phi_r[i]) << HB);
        neg7_r[i] <= neg6_r[i];
      end
      cr7_r <= cr6_r; ht7_r <= ht6_r; ad7_r <= ad6_r; s7_r <= s6_r;
    end
  end

  // dividers: quotient < 2^QB since |num| <= |den|
  localparam int TB = 3 + EB;
  logic [QB-1:0] q_w [3];
  logic rnz_w [3];
  logic [TB-1:0] tg_w [3];
  for (genvar g = 0; g < 3; g++) begin : g_div
    logic [TB-1:0] tin;
    assign tin = (g == 0) ? {cr7_r, ht7_r, neg7_r[g], s7_r[g][EB-1:0]}
                          : {1'b0, 1'b0, neg7_r[g], s7_r[g][EB-1:0]};
    sti_divider #(.NB(AB), .QB(QB), .TB(TB)) u_div (
      .clk(clk), .adv(adv), .num_in(pr7_r[g]),
      .den_in(AB'(unsigned'(ad7_r))), .tag_in(tin),
      .quo_out(q_w[g]), .rem_nz_out(rnz_w[g]), .tag_out(tg_w[g])
    );
  end

  // final stage: apply sign and truncate toward zero
  localparam int CB = QB + 2;
  sti_out_t o_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      o_r.crosses_plane <= tg_w[0][TB-1];
      o_r.hit <= tg_w[0][TB-1] & tg_w[0][TB-2];
      for (int i = 0; i < 3; i++) begin
        logic signed [CB-1:0] sv, bs;
        sv = CB'(signed'(tg_w[i][EB-1:0]));
        if (tg_w[i][EB]) begin
          bs = sv - CB'(q_w[i]);
          if (rnz_w[i] && !bs[CB-1] && bs != '0) bs = bs - CB'(1);
        end else begin
          bs = sv + CB'(q_w[i]);
          if (rnz_w[i] && bs[CB-1]) bs = bs + CB'(1);
        end
        if (!tg_w[0][TB-1]) bs = '0;
        case (i)
          0:       o_r.contact_x <= 16'(bs);
          1:       o_r.contact_y <= 16'(bs);
          default: o_r.contact_z <= 16'(bs);
        endcase
      end
    end
  end
  assign out_ch.data = o_r;
endmodule

>>> sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks segment_triangle_intersect_core against an exact integer predictor.
// A table of directed queries runs first. Random queries follow: most are a
// segment thrown through a point of the triangle's plane, and the rest are
// raw noise. Both channels idle at random, and the result side holds off for
// one long stretch.
// ---------------------------------------------------------------------------
module testbench;
  import sti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS  = 16;
  localparam int NUM_RANDOM  = 480;
  localparam int DRAIN_WAIT  = 40;
  localparam int STALL_LIMIT = 5000;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    wide_t x, y, z;
  } vec_t;

  typedef struct {
    sti_in_t  query;
    bit       known;
    sti_out_t answer;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sti_if #(.payload_t(sti_in_t))  in_ch ();
  sti_if #(.payload_t(sti_out_t)) out_ch ();

  segment_triangle_intersect_core #(.COORD_BITS(COORD_BITS)) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sti_out_t expected_hits[$];
  sti_out_t pinned_answers[$];
  bit       pinned_flags[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       hits_seen = 0;
  int       crossings_seen = 0;
  int       idle_cycles = 0;
  int       cycle_count = 0;
  bit       timed_out = 1'b0;
  bit       row_known = 1'b0;
  sti_out_t row_answer;
  bit       send_no_idle = 1'b0;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic wide_t slice_value(logic [VEC_BITS-1:0] w, int i);
    logic [15:0] raw;
    raw = w[i*16 +: 16];
    return wide_t'($signed(raw));
  endfunction

  function automatic vec_t unpack_point(logic [VEC_BITS-1:0] w);
    vec_t r;
    r.x = slice_value(w, 0);
    r.y = slice_value(w, 1);
    r.z = slice_value(w, 2);
    return r;
  endfunction

  function automatic vec_t vec_sub(vec_t p, vec_t q);
    vec_t r;
    r.x = p.x - q.x;
    r.y = p.y - q.y;
    r.z = p.z - q.z;
    return r;
  endfunction

  function automatic vec_t vec_cross(vec_t p, vec_t q);
    vec_t r;
    r.x = p.y * q.z - p.z * q.y;
    r.y = p.z * q.x - p.x * q.z;
    r.z = p.x * q.y - p.y * q.x;
    return r;
  endfunction

  function automatic wide_t vec_dot(vec_t p, vec_t q);
    return p.x * q.x + p.y * q.y + p.z * q.z;
  endfunction

  function automatic int sign_of(wide_t v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic wide_t mag(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // start + num*dv/den, truncated toward zero
  function automatic logic [15:0] contact_coord(wide_t s, wide_t dv, wide_t num,
                                                wide_t den);
    wide_t prod, quo, rem, base;
    int sg;
    prod = mag(num) * mag(dv);
    quo  = prod / mag(den);
    rem  = prod % mag(den);
    sg   = sign_of(num) * sign_of(dv) * sign_of(den);
    if (sg == 0) begin
      base = s;
    end else if (sg > 0) begin
      base = s + quo;
      if (rem != 0 && base < 0) base = base + 1;
    end else begin
      base = s - quo;
      if (rem != 0 && base > 0) base = base - 1;
    end
    return base[15:0];
  endfunction

  function automatic sti_out_t predict_intersection(sti_in_t q);
    vec_t s, e, a, b, c, n, d, as_v, bs_v, cs_v;
    wide_t ds, de, num, den;
    int sd;
    bit crosses;
    sti_out_t r;
    s = unpack_point(q.seg_start);
    e = unpack_point(q.seg_end);
    a = unpack_point(q.vertex_a);
    b = unpack_point(q.vertex_b);
    c = unpack_point(q.vertex_c);
    n = vec_cross(vec_sub(b, a), vec_sub(c, a));
    d = vec_sub(e, s);
    ds = vec_dot(n, vec_sub(s, a));
    de = vec_dot(n, vec_sub(e, a));
    num = -ds;
    den = vec_dot(n, d);
    r = '0;
    crosses = (sign_of(ds) * sign_of(de) <= 0) && (den != 0) &&
              (sign_of(num) * sign_of(den) >= 0) && (mag(num) <= mag(den));
    if (!crosses) return r;
    sd = sign_of(den);
    as_v = vec_sub(a, s);
    bs_v = vec_sub(b, s);
    cs_v = vec_sub(c, s);
    r.hit = (sign_of(vec_dot(d, vec_cross(as_v, bs_v))) * sd >= 0) &&
            (sign_of(vec_dot(d, vec_cross(bs_v, cs_v))) * sd >= 0) &&
            (sign_of(vec_dot(d, vec_cross(cs_v, as_v))) * sd >= 0);
    r.crosses_plane = 1'b1;
    r.contact_x = contact_coord(s.x, d.x, num, den);
    r.contact_y = contact_coord(s.y, d.y, num, den);
    r.contact_z = contact_coord(s.z, d.z, num, den);
    return r;
  endfunction

  function automatic logic [VEC_BITS-1:0] pack_point(int x, int y, int z);
    logic [15:0] px, py, pz;
    px = x[15:0];
    py = y[15:0];
    pz = z[15:0];
    return {pz, py, px};
  endfunction

  function automatic sti_out_t make_answer(bit h, bit cr, int x, int y, int z);
    sti_out_t r;
    r.hit = h;
    r.crosses_plane = cr;
    r.contact_x = x[15:0];
    r.contact_y = y[15:0];
    r.contact_z = z[15:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input monitor: predict every accepted transaction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_hits.push_back(predict_intersection(in_ch.data));
      pinned_flags.push_back(row_known);
      pinned_answers.push_back(row_answer);
    end
  end

  // ---------------------------------------------------------------------
  // Output checker
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    sti_out_t want, got;
    bit pinned;
    sti_out_t pin_val;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      results_seen++;
      if (got.hit) hits_seen++;
      if (got.crosses_plane) crossings_seen++;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_hits.pop_front();
        pinned = pinned_flags.pop_front();
        pin_val = pinned_answers.pop_front();
        if (pinned && pin_val != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row disagrees with predictor: row %h pred %h", pin_val, want);
        end
        if (got.hit != want.hit || got.crosses_plane != want.crosses_plane ||
            got.contact_x != want.contact_x || got.contact_y != want.contact_y ||
            got.contact_z != want.contact_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp hit=%0b cross=%0b (%0d,%0d,%0d)",
                      " got hit=%0b cross=%0b (%0d,%0d,%0d)"},
                     want.hit, want.crosses_plane, want.contact_x, want.contact_y,
                     want.contact_z, got.hit, got.crosses_plane, got.contact_x,
                     got.contact_y, got.contact_z);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: cycles without any transaction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else if (rst_n)
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Result side ready: random idling, a quiet window, one long hold-off
  // ---------------------------------------------------------------------
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (cycle_count == 600) hold = 300;
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (cycle_count > 250 && cycle_count < 550) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 38);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  task automatic send_query(sti_in_t q, bit known, sti_out_t ans);
    while (!send_no_idle && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= q;
    row_known   <= known;
    row_answer  <= ans;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [VEC_BITS-1:0] rand_point(int span);
    return pack_point($urandom_range(2*span) - span, $urandom_range(2*span) - span,
                      $urandom_range(2*span) - span);
  endfunction

  function automatic sti_in_t random_query();
    sti_in_t q;
    int span, ax, ay, az, bx, by, bz, cx, cy, cz, u, v, w, px, py, pz, ox, oy, oz, k;
    if ($urandom_range(99) < 20) begin
      q.seg_start = VEC_BITS'({$urandom, $urandom});
      q.seg_end   = VEC_BITS'({$urandom, $urandom});
      q.vertex_a  = VEC_BITS'({$urandom, $urandom});
      q.vertex_b  = VEC_BITS'({$urandom, $urandom});
      q.vertex_c  = VEC_BITS'({$urandom, $urandom});
      return q;
    end
    span = ($urandom_range(9) == 0) ? 16000 : 300;
    ax = $urandom_range(2*span) - span; ay = $urandom_range(2*span) - span;
    az = $urandom_range(2*span) - span; bx = $urandom_range(2*span) - span;
    by = $urandom_range(2*span) - span; bz = $urandom_range(2*span) - span;
    cx = $urandom_range(2*span) - span; cy = $urandom_range(2*span) - span;
    cz = $urandom_range(2*span) - span;
    // target point near the triangle, sometimes just outside it
    u = $urandom_range(12); v = $urandom_range(12 - u); w = 10 - u - v;
    px = (u*ax + v*bx + w*cx) / 10;
    py = (u*ay + v*by + w*cy) / 10;
    pz = (u*az + v*bz + w*cz) / 10;
    ox = $urandom_range(2*span) - span;
    oy = $urandom_range(2*span) - span;
    oz = $urandom_range(2*span) - span;
    k = $urandom_range(4);
    q.vertex_a  = pack_point(ax, ay, az);
    q.vertex_b  = pack_point(bx, by, bz);
    q.vertex_c  = pack_point(cx, cy, cz);
    q.seg_start = (k == 0) ? pack_point(px, py, pz) : pack_point(px + ox, py + oy, pz + oz);
    q.seg_end   = (k == 4) ? rand_point(span)
                           : pack_point(px - ox/(k+1), py - oy/(k+1), pz - oz/(k+1));
    return q;
  endfunction

  initial begin
    row_t rows[$];
    row_t r;
    sti_in_t q;
    sti_out_t none;
    logic [VEC_BITS-1:0] ta, tb, tc, mx, mn;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    row_answer  = '0;

    ta = pack_point(0, 0, 0);
    tb = pack_point(16, 0, 0);
    tc = pack_point(0, 16, 0);
    mx = pack_point(32767, 32767, 32767);
    mn = pack_point(-32768, -32768, -32768);

    // all zero: degenerate triangle
    rows.push_back('{'{'0, '0, '0, '0, '0}, 1, none});
    // straight through the interior
    rows.push_back('{'{pack_point(4, 4, -16), pack_point(4, 4, 16), ta, tb, tc}, 1,
                     make_answer(1, 1, 4, 4, 0)});
    // crosses the plane outside the triangle
    rows.push_back('{'{pack_point(32, 32, -16), pack_point(32, 32, 16), ta, tb, tc}, 1,
                     make_answer(0, 1, 32, 32, 0)});
    // entirely above the plane
    rows.push_back('{'{pack_point(4, 4, 16), pack_point(4, 4, 32), ta, tb, tc}, 1, none});
    // start point on the plane
    rows.push_back('{'{pack_point(4, 4, 0), pack_point(4, 4, 16), ta, tb, tc}, 1,
                     make_answer(1, 1, 4, 4, 0)});
    // end point on the plane, reversed direction
    rows.push_back('{'{pack_point(4, 4, 16), pack_point(4, 4, 0), ta, tb, tc}, 1,
                     make_answer(1, 1, 4, 4, 0)});
    // segment lying in the plane
    rows.push_back('{'{pack_point(1, 1, 0), pack_point(5, 2, 0), ta, tb, tc}, 1, none});
    // parallel above the plane
    rows.push_back('{'{pack_point(1, 1, 8), pack_point(5, 2, 8), ta, tb, tc}, 1, none});
    // on an edge and on a vertex
    rows.push_back('{'{pack_point(8, 0, -16), pack_point(8, 0, 16), ta, tb, tc}, 1,
                     make_answer(1, 1, 8, 0, 0)});
    rows.push_back('{'{pack_point(16, 0, -16), pack_point(16, 0, 16), ta, tb, tc}, 1,
                     make_answer(1, 1, 16, 0, 0)});
    // degenerate collinear triangle
    rows.push_back('{'{pack_point(4, 0, -16), pack_point(4, 0, 16), ta, tb,
                       pack_point(32, 0, 0)}, 1, none});
    // fractional crossing, rounding toward zero both signs
    rows.push_back('{'{pack_point(1, 1, -1), pack_point(4, -4, 2), ta, tb, tc}, 0, none});
    rows.push_back('{'{pack_point(-1, 5, -2), pack_point(-4, 9, 1), ta, tb, tc}, 0, none});
    // clockwise winding
    rows.push_back('{'{pack_point(4, 4, 16), pack_point(4, 4, -16), ta, tc, tb}, 0, none});
    // coordinate extremes
    rows.push_back('{'{mn, mx, pack_point(-32768, 0, 0), pack_point(32767, -32768, 0),
                       pack_point(0, 32767, 0)}, 0, none});
    rows.push_back('{'{mx, mn, pack_point(32767, 32767, -32768),
                       pack_point(-32768, 32767, 32767), pack_point(32767, -32768, 32767)},
                     0, none});
    rows.push_back('{'{mx, mx, mx, mn, mx}, 0, none});
    rows.push_back('{'{mn, mx, mx, mn, pack_point(32767, -32768, 0)}, 0, none});
    rows.push_back('{'{{48{1'b1}}, '0, {48{1'b1}}, '0, {3{16'h5555}}}, 0, none});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (rows[i]) begin
      r = rows[i];
      send_query(r.query, r.known, r.answer);
    end

    // random traffic
    for (int i = 0; i < NUM_RANDOM; i++) begin
      send_no_idle = (i >= 150 && i < 250);
      if (i == 350) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_hits.size() != 0) @(posedge clk);
      end
      q = random_query();
      send_query(q, 1'b0, none);
    end
    in_ch.valid <= 1'b0;
    row_known   <= 1'b0;

    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("checked %0d results: %0d plane crossings, %0d triangle hits",
             results_seen, crossings_seen, hits_seen);
    $display("directed edge, vertex, extreme and degenerate cases plus random throws");
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
